@@ rtl/vda_pkg.sv @@
package vda_pkg;

  // Field widths are fixed by the stream format
  localparam int unsigned FieldWidth  = 16;
  // Low bits of each element field taken as a two's complement value
  localparam int unsigned ElemWidth   = 16;
  localparam int unsigned DiffWidth   = ElemWidth + 1;
  localparam int unsigned TermWidth   = 2 * DiffWidth;
  localparam int unsigned DistWidth   = 48;
  localparam int unsigned PrefixWidth = 27;
  localparam int unsigned ModeWidth   = 2;

  typedef enum logic [ModeWidth-1:0] {
    MODE_EUCLID    = 2'd0,
    MODE_SQ_EUCLID = 2'd1,
    MODE_CITY      = 2'd2,
    MODE_EMD       = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TERM = 5'b00010,
    S_ACC  = 5'b00100,
    S_SQRT = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;       // capture an accepted transaction
    logic term;       // form the per-element term
    logic accum;      // saturating add into the accumulator
    logic sqrt_step;  // one result bit of the square root
    logic emit;       // load the output register, clear state
  } cmd_t;

  typedef struct packed {
    logic last;
    logic euclid;
    logic sqrt_last;
    logic out_free;
  } status_t;

  function automatic logic signed [DiffWidth-1:0] sext_elem(
    input logic [FieldWidth-1:0] raw
  );
    logic signed [ElemWidth-1:0] v;
    v = signed'(raw[ElemWidth-1:0]);
    return DiffWidth'(v);
  endfunction

endpackage

@@ rtl/vda_stream_if.sv @@
interface vda_in_if;
  import vda_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [FieldWidth-1:0] x_elem;
  logic signed [FieldWidth-1:0] y_elem;
  logic                         last;

  modport source (output valid, output x_elem, output y_elem, output last, input ready);
  modport sink   (input valid, input x_elem, input y_elem, input last, output ready);
endinterface

interface vda_out_if;
  import vda_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DistWidth-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

@@ rtl/vda_ctrl.sv @@
module vda_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vda_pkg::status_t status_i,
  output vda_pkg::cmd_t    cmd_o
);
  import vda_pkg::*;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TERM;
        end
      end
      S_TERM: begin
        cmd_o.term = 1'b1;
        state_d    = S_ACC;
      end
      S_ACC: begin
        cmd_o.accum = 1'b1;
        if (!status_i.last) begin
          state_d = S_IDLE;
        end else if (status_i.euclid) begin
          state_d = S_SQRT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/vda_datapath.sv @@
module vda_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vda_pkg::ModeWidth-1:0]   cfg_wdata_i,
  input  logic [vda_pkg::FieldWidth-1:0]  x_elem_i,
  input  logic [vda_pkg::FieldWidth-1:0]  y_elem_i,
  input  logic                            last_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [vda_pkg::DistWidth-1:0]   distance_o,
  input  vda_pkg::cmd_t                   cmd_i,
  output vda_pkg::status_t                status_o
);
  import vda_pkg::*;

  localparam int unsigned PfxSumWidth = PrefixWidth + 1;

  mode_e                         mode_q;        // configuration register
  mode_e                         item_mode_q;   // mode at the element's step
  logic                          last_q;
  logic signed [DiffWidth-1:0]   diff_q;
  logic signed [PrefixWidth-1:0] prefix_q, prefix_d;
  logic [TermWidth-1:0]          term_q, term_d;
  logic [DistWidth-1:0]          acc_q, acc_sat;
  logic [DistWidth:0]            acc_sum;
  logic [DistWidth-1:0]          sq_rem_q, sq_root_q, sq_bit_q, sq_trial;
  logic                          out_valid_q;
  logic [DistWidth-1:0]          distance_q;

  logic signed [DiffWidth-1:0]   diff_d;
  logic signed [PfxSumWidth-1:0] pfx_sum;
  logic [DiffWidth-1:0]          abs_diff;
  logic [PrefixWidth-1:0]        abs_pfx;

  // x - y, and the running prefix of y - x saturated to 27 bits
  assign diff_d  = sext_elem(x_elem_i) - sext_elem(y_elem_i);
  assign pfx_sum = PfxSumWidth'(prefix_q) - PfxSumWidth'(diff_d);

  always_comb begin
    if (pfx_sum[PfxSumWidth-1] != pfx_sum[PfxSumWidth-2]) begin
      prefix_d = pfx_sum[PfxSumWidth-1] ? {1'b1, {(PrefixWidth-1){1'b0}}}
                                        : {1'b0, {(PrefixWidth-1){1'b1}}};
    end else begin
      prefix_d = pfx_sum[PrefixWidth-1:0];
    end
  end

  assign abs_diff = diff_q[DiffWidth-1] ? DiffWidth'(-diff_q) : DiffWidth'(diff_q);
  assign abs_pfx  = prefix_q[PrefixWidth-1] ? PrefixWidth'(-prefix_q)
                                            : PrefixWidth'(prefix_q);

  always_comb begin
    case (item_mode_q)
      MODE_EUCLID, MODE_SQ_EUCLID: term_d = TermWidth'(abs_diff * abs_diff);
      MODE_CITY:                   term_d = TermWidth'(abs_diff);
      MODE_EMD:                    term_d = TermWidth'(abs_pfx);
      default:                     term_d = '0;
    endcase
  end

  assign acc_sum  = {1'b0, acc_q} + (DistWidth + 1)'(term_q);
  assign acc_sat  = acc_sum[DistWidth] ? '1 : acc_sum[DistWidth-1:0];
  assign sq_trial = sq_root_q + sq_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_EUCLID;
      prefix_q    <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= mode_e'(cfg_wdata_i);
      end
      if (cmd_i.load) begin
        prefix_q <= prefix_d;
      end else if (cmd_i.emit) begin
        prefix_q <= '0;
      end
      if (cmd_i.accum) begin
        acc_q <= acc_sat;
      end else if (cmd_i.emit) begin
        acc_q <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      diff_q      <= diff_d;
      last_q      <= last_i;
      item_mode_q <= mode_q;
    end
    if (cmd_i.term) begin
      term_q <= term_d;
    end
    // square root: one result bit per step, seeded from the final sum
    if (cmd_i.accum) begin
      sq_rem_q  <= acc_sat;
      sq_root_q <= '0;
      sq_bit_q  <= DistWidth'(1) << (DistWidth - 2);
    end else if (cmd_i.sqrt_step) begin
      if (sq_rem_q >= sq_trial) begin
        sq_rem_q  <= sq_rem_q - sq_trial;
        sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
      end else begin
        sq_root_q <= sq_root_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
    if (cmd_i.emit) begin
      distance_q <= (item_mode_q == MODE_EUCLID) ? sq_root_q : acc_q;
    end
  end

  assign status_o.last      = last_q;
  assign status_o.euclid    = (item_mode_q == MODE_EUCLID);
  assign status_o.sqrt_last = sq_bit_q[0];
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign distance_o  = distance_q;

endmodule

@@ rtl/vector_distance_accumulator.sv @@
// Vector distance accumulator. Element pairs (x, y) stream in as transactions,
// one pair each, and the transaction flagged last closes the vector: one
// result transaction then carries the distance under the mode register
// (0 Euclidean = floor isqrt of the sum of squared differences, 1 squared
// Euclidean, 2 city block, 3 unnormalised earth mover = sum of absolute
// running prefix differences of y - x). The 48-bit sum saturates at all ones
// and the prefix difference at the 27-bit signed limits. Each element is
// summed under the mode in force when it was accepted; the result uses the
// mode of the last element. Each transaction passes capture, term (the
// 17x17 multiply stage) and accumulate (the 48-bit saturating add stage);
// a new transaction is taken only after the last one is accumulated. A
// last element then loads the output register once it is free, in
// Euclidean mode after a square root that resolves one result bit a cycle.
// The result register frees the input side: the block carries on with the
// next vector while a result waits, holding only when a second result is
// ready before the first is taken. Write mode only while idle.
module vector_distance_accumulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vda_pkg::ModeWidth-1:0] cfg_wdata_i,
  vda_in_if.sink                        in_if,
  vda_out_if.source                     out_if
);
  import vda_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: capture -> term -> accumulate [-> sqrt] [-> emit]
  vda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic, state registers, config register and output register
  vda_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .x_elem_i    (in_if.x_elem),
    .y_elem_i    (in_if.y_elem),
    .last_i      (in_if.last),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .distance_o  (out_if.distance),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

@@ rtl/vda_checker.sv @@
module vda_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [47:0] distance_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(distance_i))
    else $error("result changed while stalled");

  // each element passes term and accumulate before the next is taken: no back-to-back transactions
  a_no_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i ##1 !in_ready_i)
    else $error("input taken too soon after a transaction");

  // a fresh result never follows an input transaction before its term and accumulate steps are done
  a_res_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_acc, 1) && !$past(in_acc, 2))
    else $error("result too soon after input");

endmodule

bind vector_distance_accumulator vda_checker u_vda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .distance_i  (out_if.distance)
);

@@ tb/sv/vda_distance_checker.sv @@
module vda_distance_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vda_pkg::ModeWidth-1:0] cfg_wdata_i,
  vda_in_if                             in_mon,
  vda_out_if                            out_mon,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_o,
  output int unsigned                   elements_o,
  output int unsigned                   distances_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import vda_pkg::*;

  localparam longint PREFIX_HI = (longint'(1) << (PrefixWidth - 1)) - 1;
  localparam longint PREFIX_LO = -(longint'(1) << (PrefixWidth - 1));

  mode_e                         mode_q;
  logic [DistWidth-1:0]          acc_q;
  logic signed [PrefixWidth-1:0] prefix_q;
  logic [DistWidth-1:0]          expected_dist_q[$];
  int unsigned                   fail_count;

  // low ElemWidth bits of a field, two's complement
  function automatic longint elem_value(input logic [FieldWidth-1:0] raw);
    logic signed [ElemWidth-1:0] v;
    v = raw[ElemWidth-1:0];
    return longint'(v);
  endfunction

  function automatic logic [DistWidth-1:0] floor_sqrt(input logic [DistWidth-1:0] v);
    logic [DistWidth-1:0] root;
    logic [DistWidth-1:0] trial;
    root = '0;
    for (int b = DistWidth / 2 - 1; b >= 0; b--) begin
      trial = root | (DistWidth'(1) << b);
      if (longint'(trial) * longint'(trial) <= longint'(v)) root = trial;
    end
    return root;
  endfunction

  task automatic absorb_element(input logic [FieldWidth-1:0] xr,
                                input logic [FieldWidth-1:0] yr,
                                input logic                  closes);
    longint               xv;
    longint               yv;
    longint               diff;
    longint               pref;
    longint               term;
    logic [DistWidth:0]   sum;
    logic [DistWidth-1:0] exp_dist;
    xv   = elem_value(xr);
    yv   = elem_value(yr);
    diff = xv - yv;
    // prefix of y - x is tracked whatever the mode
    pref = longint'(prefix_q) + (yv - xv);
    if (pref > PREFIX_HI) pref = PREFIX_HI;
    else if (pref < PREFIX_LO) pref = PREFIX_LO;
    prefix_q = PrefixWidth'(pref);
    case (mode_q)
      MODE_EUCLID, MODE_SQ_EUCLID: term = diff * diff;
      MODE_CITY:                   term = (diff < 0) ? -diff : diff;
      default:                     term = (pref < 0) ? -pref : pref;
    endcase
    sum   = {1'b0, acc_q} + (DistWidth + 1)'(term);
    acc_q = sum[DistWidth] ? '1 : sum[DistWidth-1:0];
    if (closes) begin
      exp_dist = (mode_q == MODE_EUCLID) ? floor_sqrt(acc_q) : acc_q;
      expected_dist_q.push_back(exp_dist);
      acc_q    = '0;
      prefix_q = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [DistWidth-1:0] want;
    logic                 have_want;
    if (!rst_ni) begin
      mode_q   = MODE_EUCLID;
      acc_q    = '0;
      prefix_q = '0;
      expected_dist_q.delete();
      fail_count = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      elements_o   <= 0;
      distances_o  <= 0;
    end else begin
      // results first: a result never stems from the element taken this edge
      if (out_mon.valid && out_mon.ready) begin
        have_want = expected_dist_q.size() != 0;
        want      = 'x;
        if (have_want) want = expected_dist_q.pop_front();
        if (!have_want || out_mon.distance !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("distance mismatch at %0t: expected %0d, got %0d",
                     $time, want, out_mon.distance);
        end
        distances_o <= distances_o + 1;
      end
      if (in_mon.valid && in_mon.ready) begin
        absorb_element(in_mon.x_elem, in_mon.y_elem, in_mon.last);
        elements_o <= elements_o + 1;
      end
      if (cfg_we_i) mode_q = mode_e'(cfg_wdata_i);
      mismatches_o <= fail_count;
      pending_o    <= expected_dist_q.size();
    end
  end

endmodule

@@ tb/sv/vector_distance_accumulator_test.sv @@
module vector_distance_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vda_pkg::*;

  // Cycles to let the block go quiet after the last result: capture, term,
  // accumulate, output load and the 24-step root, with margin.
  localparam int SETTLE_CYCLES = 40;
  // Receiver hold-off long enough to fill the result register and stall input
  localparam int HOLD_CYCLES   = 400;
  // Guard on the whole run; the slowest correct run is well under half this
  localparam int LIMIT_CYCLES  = 2_000_000;
  // Earth mover run: 1025 steps of 65535 pass the upper prefix limit
  localparam int PFX_LEN       = 1030;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 64;

  localparam logic [FieldWidth-1:0] ELEM_MAX = {1'b0, {(FieldWidth - 1){1'b1}}};
  localparam logic [FieldWidth-1:0] ELEM_MIN = {1'b1, {(FieldWidth - 1){1'b0}}};

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [ModeWidth-1:0] cfg_wdata;

  // no idling on either side while set
  logic                 quiet;
  // each increment asks the receiver for one long hold-off
  int unsigned          holdoff_req;
  int unsigned          cycle_count = 0;

  int unsigned          mismatches;
  int unsigned          pending;
  int unsigned          elements;
  int unsigned          distances;

  vda_in_if  in_if ();
  vda_out_if out_if ();

  vector_distance_accumulator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  vda_distance_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .elements_o   (elements),
    .distances_o  (distances)
  );

  always #5 clk_i = ~clk_i;

  // Run guard: anything still hanging here is a failure
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d distances still due", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random ready, but a requested hold-off is counted out here
  initial begin : receiver
    int unsigned served;
    int          hold_left;
    served    = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (served != holdoff_req) begin
        served    = holdoff_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet || ($urandom_range(99) >= 30);
      end
    end
  end

  // Offer one element pair; returns at the edge that accepts the transaction.
  // Valid is left high so a following transaction can go back to back.
  task automatic send_pair(input logic [FieldWidth-1:0] x,
                           input logic [FieldWidth-1:0] y,
                           input logic                  closes);
    while (!quiet && $urandom_range(99) < 30) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.x_elem <= x;
    in_if.y_elem <= y;
    in_if.last   <= closes;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stop offering, wait for every due distance, then let the block drain an
  // open vector's last term; only after this is a mode write safe.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input mode_e m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Mostly full-range values, with extremes, zero and small values mixed in
  function automatic logic [FieldWidth-1:0] rand_elem();
    case ($urandom_range(9))
      0:       return ELEM_MAX;
      1:       return ELEM_MIN;
      2:       return FieldWidth'($urandom_range(16)) - FieldWidth'(8);
      3:       return '0;
      default: return FieldWidth'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int left;
    int span;
    left = 0;
    span = 0;
    quiet       <= 1'b0;
    holdoff_req <= 0;
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_if.valid  <= 1'b0;
    in_if.x_elem <= '0;
    in_if.y_elem <= '0;
    in_if.last   <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Euclidean from reset: widest differences both ways, a zero vector,
    // and a small exact root
    send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    send_pair('0, '0, 1'b1);
    send_pair(FieldWidth'(-3), FieldWidth'(1), 1'b1);

    settle();
    write_mode(MODE_SQ_EUCLID);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b0);
    send_pair(FieldWidth'(1), FieldWidth'(-1), 1'b0);
    send_pair('0, '0, 1'b1);

    settle();
    write_mode(MODE_CITY);
    send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
    send_pair(FieldWidth'(-1), '0, 1'b0);
    send_pair(FieldWidth'(100), FieldWidth'(-100), 1'b1);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);

    settle();
    write_mode(MODE_EMD);
    send_pair('0, FieldWidth'(5), 1'b0);
    send_pair(FieldWidth'(3), '0, 1'b0);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    // leave a vector open, switch to city block, then close it
    send_pair(FieldWidth'(10), '0, 1'b0);
    send_pair('0, FieldWidth'(-7), 1'b0);
    settle();
    write_mode(MODE_CITY);
    send_pair(FieldWidth'(4), FieldWidth'(9), 1'b1);

    // One-element vectors while the receiver holds off: the result register
    // fills and the input side has to stall
    holdoff_req <= holdoff_req + 1;
    for (int n = 0; n < 48; n++) send_pair(rand_elem(), rand_elem(), 1'b1);

    // Earth mover with the prefix driven into its upper limit, no idling at all
    settle();
    write_mode(MODE_EMD);
    quiet <= 1'b1;
    for (int n = 0; n < PFX_LEN; n++) send_pair(ELEM_MIN, ELEM_MAX, 1'b0);
    send_pair('0, '0, 1'b1);
    quiet <= 1'b0;

    // Random vectors in phases; a phase may end mid-vector, so the mode
    // write that follows also lands inside an open vector
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      write_mode(mode_e'((ph < 4) ? ph : $urandom_range(3)));
      quiet <= (ph == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (left == 0) begin
          span = ($urandom_range(9) == 0) ? $urandom_range(60, 9) : $urandom_range(8, 1);
          left = span;
        end
        left--;
        send_pair(rand_elem(), rand_elem(),
                  (left == 0) || (ph == RAND_PHASES - 1 && n == PHASE_ITEMS - 1));
      end
    end

    // Drain: every distance in, then the block's latency once more
    in_if.valid <= 1'b0;
    quiet       <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d element pairs streamed, %0d distances checked over all four modes,",
             elements, distances);
    $display("with prefix saturation, mid-vector mode changes and output stalls");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d distance mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ vector_distance_accumulator.f @@
rtl/vda_pkg.sv
rtl/vda_stream_if.sv
rtl/vda_ctrl.sv
rtl/vda_datapath.sv
rtl/vector_distance_accumulator.sv
rtl/vda_checker.sv
tb/sv/vda_distance_checker.sv
tb/sv/vector_distance_accumulator_test.sv
